[design/lut3d_pkg.sv]
// Shared constants for the 3D LUT color mapper: fixed-point format,
// request codes and the linear interpolation step. No dependencies.
package lut3d_pkg;

    localparam int FRAC_BITS = 15;
    localparam int PIX_W     = 16;
    localparam int VAL_W     = 17;
    localparam int ENT_W     = 3 * VAL_W;
    localparam logic [PIX_W-1:0] ONE_VAL  = PIX_W'(1) << FRAC_BITS;
    localparam logic [PIX_W-1:0] ZERO_VAL = '0;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef logic signed [VAL_W-1:0] t_val;

    // a + (b - a) * d / ONE, round half up; between a and b for d <= ONE
    function automatic t_val lerp(input t_val a, input t_val b, input logic [PIX_W-1:0] d);
        logic signed [VAL_W:0]            diff;
        logic signed [VAL_W+PIX_W+1:0]    prod;
        logic signed [VAL_W+PIX_W+2:0]    acc;
        diff = VAL_W'(0) + {b[VAL_W-1], b} - {a[VAL_W-1], a};
        prod = diff * $signed({1'b0, d});
        acc  = ($signed({{(PIX_W+2){a[VAL_W-1]}}, a}) <<< FRAC_BITS)
             + {prod[VAL_W+PIX_W+1], prod}
             + (VAL_W+PIX_W+3)'(1 << (FRAC_BITS - 1));
        return acc[FRAC_BITS+VAL_W-1:FRAC_BITS];
    endfunction

    function automatic logic [PIX_W-1:0] clamp_unit(input t_val v);
        if (v < 0) begin
            return ZERO_VAL;
        end else if (v > $signed({1'b0, ONE_VAL})) begin
            return ONE_VAL;
        end
        return v[PIX_W-1:0];
    endfunction

endpackage

[design/lut3d_trilinear_color_map.sv]
// Top level of the 3D LUT trilinear color mapper.
// Depends on lut3d_pkg.
//
// Takes one item per clock while the output is not stalled. A pixel item
// runs through the input, index, corner read and interpolation stages to
// o_valid; a load item writes the LUT from the base flat index stage and
// gives no result. The LUT is held in four identical copies, each with two
// read ports, so all eight cell corners are read in a single cycle; the grid
// index arithmetic and the three interpolation levels have their own register
// stages. A stall on a valid output freezes the whole pipeline, bubbles included.
module lut3d_trilinear_color_map import lut3d_pkg::*; #(
    parameter int GRID_MAX = 33
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_grid_size_we,
    input  logic [5:0]              i_grid_size,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_req_type,
    input  logic [15:0]             i_entry_index,
    input  logic signed [VAL_W-1:0] i_entry_red,
    input  logic signed [VAL_W-1:0] i_entry_green,
    input  logic signed [VAL_W-1:0] i_entry_blue,
    input  logic [PIX_W-1:0]        i_pix_red,
    input  logic [PIX_W-1:0]        i_pix_green,
    input  logic [PIX_W-1:0]        i_pix_blue,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PIX_W-1:0]        o_out_red,
    output logic [PIX_W-1:0]        o_out_green,
    output logic [PIX_W-1:0]        o_out_blue
);

    localparam int DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(GRID_MAX + 1);
    localparam int CW    = $clog2(GRID_MAX);
    localparam int PW    = PIX_W + NW;
    localparam int IW    = (AW > 16) ? AW + 1 : 17;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic [5:0] r_grid_size;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= 6'd33;
        end else if (i_grid_size_we) begin
            r_grid_size <= i_grid_size;
        end
    end

    logic [NW-1:0] n_eff;
    always_comb begin
        if ({1'b0, r_grid_size} < 7'd2) begin
            n_eff = NW'(2);
        end else if (32'(r_grid_size) > GRID_MAX) begin
            n_eff = NW'(GRID_MAX);
        end else begin
            n_eff = NW'(r_grid_size);
        end
    end

    // valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8} <= '0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5 && (r_t5 == REQ_PIXEL);
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end
    assign o_valid = r_v8;

    // stage 1: input register
    logic             r_t1;
    logic [15:0]      r_idx1;
    logic [ENT_W-1:0] r_ent1;
    logic [PIX_W-1:0] r_pix1 [3];

    // stage 2: cell base and fraction
    logic             r_t2;
    logic [15:0]      r_idx2;
    logic [ENT_W-1:0] r_ent2;
    logic [NW-1:0]    r_n2;
    logic [CW-1:0]    r_base2 [3];
    logic [PIX_W-1:0] r_frac2 [3];

    // stage 3: g + n*b and n*n
    logic             r_t3;
    logic [15:0]      r_idx3;
    logic [ENT_W-1:0] r_ent3;
    logic [NW-1:0]    r_n3;
    logic [2*NW-1:0]  r_nn3;
    logic [CW-1:0]    r_r3;
    logic [AW-1:0]    r_gb3;
    logic [PIX_W-1:0] r_frac3 [3];

    // stage 4: base flat index
    logic             r_t4;
    logic [15:0]      r_idx4;
    logic [ENT_W-1:0] r_ent4;
    logic [NW-1:0]    r_n4;
    logic [2*NW-1:0]  r_nn4;
    logic [AW-1:0]    r_a4;
    logic [PIX_W-1:0] r_frac4 [3];

    // stage 5: corner data
    logic             r_t5;
    logic [ENT_W-1:0] corner5 [8];
    logic [PIX_W-1:0] r_frac5 [3];

    // stages 6..8: interpolation levels
    t_val             r_x6 [3][4];
    logic [PIX_W-1:0] r_frac6 [2];
    t_val             r_y7 [3][2];
    logic [PIX_W-1:0] r_frac7;

    logic [PW-1:0]    pos   [3];
    logic [PW-1:0]    based [3];
    logic [PIX_W-1:0] psat  [3];
    logic [PW-1:0]    bsel  [3];
    logic [AW-1:0]    caddr [8];
    logic             wr_en;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            psat[c] = (r_pix1[c] > ONE_VAL) ? ONE_VAL : r_pix1[c];
            pos[c]  = PW'(psat[c]) * PW'(n_eff - NW'(1));
            based[c] = pos[c] >> FRAC_BITS;
            bsel[c] = (based[c] > PW'(n_eff - NW'(2))) ? PW'(n_eff - NW'(2)) : based[c];
        end
        for (int k = 0; k < 8; k++) begin
            caddr[k] = r_a4 + AW'(k & 1)
                     + (((k >> 1) & 1) != 0 ? AW'(r_n4) : AW'(0))
                     + (((k >> 2) & 1) != 0 ? AW'(r_nn4) : AW'(0));
        end
        wr_en = en && r_v4 && (r_t4 == REQ_LOAD) && (IW'(r_idx4) < IW'(DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1      <= i_req_type;
            r_idx1    <= i_entry_index;
            r_ent1    <= {i_entry_blue, i_entry_green, i_entry_red};
            r_pix1[0] <= i_pix_red;
            r_pix1[1] <= i_pix_green;
            r_pix1[2] <= i_pix_blue;

            r_t2   <= r_t1;
            r_idx2 <= r_idx1;
            r_ent2 <= r_ent1;
            r_n2   <= n_eff;
            for (int c = 0; c < 3; c++) begin
                r_base2[c] <= CW'(bsel[c]);
                r_frac2[c] <= PIX_W'(pos[c] - (bsel[c] << FRAC_BITS));
            end

            r_t3    <= r_t2;
            r_idx3  <= r_idx2;
            r_ent3  <= r_ent2;
            r_n3    <= r_n2;
            r_nn3   <= (2*NW)'(r_n2) * (2*NW)'(r_n2);
            r_r3    <= r_base2[0];
            r_gb3   <= AW'(r_base2[1]) + AW'(r_n2) * AW'(r_base2[2]);
            r_frac3 <= r_frac2;

            r_t4    <= r_t3;
            r_idx4  <= r_idx3;
            r_ent4  <= r_ent3;
            r_n4    <= r_n3;
            r_nn4   <= r_nn3;
            r_a4    <= AW'(r_r3) + AW'(r_n3) * r_gb3;
            r_frac4 <= r_frac3;

            r_t5    <= r_t4;
            r_frac5 <= r_frac4;

            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 4; j++) begin
                    r_x6[c][j] <= lerp(t_val'(corner5[2*j][c*VAL_W +: VAL_W]),
                                       t_val'(corner5[2*j+1][c*VAL_W +: VAL_W]),
                                       r_frac5[0]);
                end
            end
            r_frac6[0] <= r_frac5[1];
            r_frac6[1] <= r_frac5[2];

            for (int c = 0; c < 3; c++) begin
                r_y7[c][0] <= lerp(r_x6[c][0], r_x6[c][1], r_frac6[0]);
                r_y7[c][1] <= lerp(r_x6[c][2], r_x6[c][3], r_frac6[0]);
            end
            r_frac7 <= r_frac6[1];

            o_out_red   <= clamp_unit(lerp(r_y7[0][0], r_y7[0][1], r_frac7));
            o_out_green <= clamp_unit(lerp(r_y7[1][0], r_y7[1][1], r_frac7));
            o_out_blue  <= clamp_unit(lerp(r_y7[2][0], r_y7[2][1], r_frac7));
        end
    end

    // four LUT copies, two read ports each
    for (genvar m = 0; m < 4; m++) begin : g_copy
        logic [ENT_W-1:0] mem [DEPTH];
        logic [ENT_W-1:0] r_rd [2];
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                mem[AW'(r_idx4)] <= r_ent4;
            end
            if (en) begin
                r_rd[0] <= mem[caddr[2*m]];
                r_rd[1] <= mem[caddr[2*m+1]];
            end
        end
    end

    always_comb begin
        corner5 = '{g_copy[0].r_rd[0], g_copy[0].r_rd[1],
                    g_copy[1].r_rd[0], g_copy[1].r_rd[1],
                    g_copy[2].r_rd[0], g_copy[2].r_rd[1],
                    g_copy[3].r_rd[0], g_copy[3].r_rd[1]};
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for lut3d_trilinear_color_map: LUT loads and pixel items against a
// trilinear mapping predictor, with random gaps, stalls and grid sizes.
// Depends on lut3d_pkg and the lut3d_trilinear_color_map RTL.
module tb;
    import lut3d_pkg::*;

    localparam int GRID_MAX    = 33;
    localparam int STORE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 16;
    localparam int ITEM_TARGET = 750;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_mapped_pix;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_grid_size_we = 1'b0;
    logic [5:0]              i_grid_size = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_req_type = REQ_LOAD;
    logic [15:0]             i_entry_index = '0;
    logic signed [VAL_W-1:0] i_entry_red = '0;
    logic signed [VAL_W-1:0] i_entry_green = '0;
    logic signed [VAL_W-1:0] i_entry_blue = '0;
    logic [PIX_W-1:0]        i_pix_red = '0;
    logic [PIX_W-1:0]        i_pix_green = '0;
    logic [PIX_W-1:0]        i_pix_blue = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [PIX_W-1:0]        o_out_red;
    logic [PIX_W-1:0]        o_out_green;
    logic [PIX_W-1:0]        o_out_blue;

    lut3d_trilinear_color_map #(.GRID_MAX(GRID_MAX)) uut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [VAL_W-1:0] lut_red   [STORE_DEPTH];
    logic signed [VAL_W-1:0] lut_green [STORE_DEPTH];
    logic signed [VAL_W-1:0] lut_blue  [STORE_DEPTH];
    bit                      lut_written [STORE_DEPTH];
    logic [5:0]              grid_reg = 6'd33;
    t_mapped_pix             mapped_q[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  item_count = 0;
    int  burst_left = 0;
    bit  no_gaps = 1'b0;
    int  hold_cycles = 0;

    function automatic int eff_grid();
        if (grid_reg < 2) return 2;
        if (grid_reg > GRID_MAX) return GRID_MAX;
        return int'(grid_reg);
    endfunction

    function automatic void axis_split(input logic [15:0] p, input int n,
                                       output int base, output longint frac);
        longint pos;
        longint pc;
        pc = (p > ONE_VAL) ? longint'(ONE_VAL) : longint'(p);
        pos = pc * (n - 1);
        base = int'(pos >>> FRAC_BITS);
        if (base > n - 2) base = n - 2;
        frac = pos - (longint'(base) <<< FRAC_BITS);
    endfunction

    function automatic longint lerp_step(longint a, longint b, longint d);
        longint acc;
        acc = a * (longint'(ONE_VAL) - d) + b * d + (longint'(1) <<< (FRAC_BITS - 1));
        return acc >>> FRAC_BITS;
    endfunction

    function automatic int corner_index(logic [15:0] pr, logic [15:0] pg,
                                        logic [15:0] pb, int k);
        int n, r0, g0, b0;
        longint dr, dg, db;
        n = eff_grid();
        axis_split(pr, n, r0, dr);
        axis_split(pg, n, g0, dg);
        axis_split(pb, n, b0, db);
        return (r0 + (k & 1)) + n * ((g0 + ((k >> 1) & 1)) + n * (b0 + ((k >> 2) & 1)));
    endfunction

    function automatic logic [15:0] clamp_channel(longint v);
        if (v < 0) return '0;
        if (v > longint'(ONE_VAL)) return ONE_VAL;
        return v[15:0];
    endfunction

    function automatic t_mapped_pix map_pixel(logic [15:0] pr, logic [15:0] pg,
                                              logic [15:0] pb);
        int n, r0, g0, b0, idx;
        longint dr, dg, db;
        longint v[3][8];
        longint x00, x10, x01, x11, y0, y1;
        longint res[3];
        t_mapped_pix m;
        n = eff_grid();
        axis_split(pr, n, r0, dr);
        axis_split(pg, n, g0, dg);
        axis_split(pb, n, b0, db);
        for (int k = 0; k < 8; k++) begin
            idx = (r0 + (k & 1)) + n * ((g0 + ((k >> 1) & 1)) + n * (b0 + ((k >> 2) & 1)));
            v[0][k] = lut_red[idx];
            v[1][k] = lut_green[idx];
            v[2][k] = lut_blue[idx];
        end
        for (int c = 0; c < 3; c++) begin
            x00 = lerp_step(v[c][0], v[c][1], dr);
            x10 = lerp_step(v[c][2], v[c][3], dr);
            x01 = lerp_step(v[c][4], v[c][5], dr);
            x11 = lerp_step(v[c][6], v[c][7], dr);
            y0 = lerp_step(x00, x10, dg);
            y1 = lerp_step(x01, x11, dg);
            res[c] = lerp_step(y0, y1, db);
        end
        m.red   = clamp_channel(res[0]);
        m.green = clamp_channel(res[1]);
        m.blue  = clamp_channel(res[2]);
        return m;
    endfunction

    // sends one item; predictor updated at acceptance
    task automatic send_item(logic req, logic [15:0] idx, logic signed [16:0] er,
                             logic signed [16:0] eg, logic signed [16:0] eb,
                             logic [15:0] pr, logic [15:0] pg, logic [15:0] pb);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_entry_index <= idx;
        i_entry_red <= er;
        i_entry_green <= eg;
        i_entry_blue <= eb;
        i_pix_red <= pr;
        i_pix_green <= pg;
        i_pix_blue <= pb;
        do @(posedge i_clk); while (o_stall);
        item_count++;
        if (req == REQ_PIXEL) begin
            mapped_q = {mapped_q, map_pixel(pr, pg, pb)};
        end else if (idx < STORE_DEPTH) begin
            lut_red[idx] = er;
            lut_green[idx] = eg;
            lut_blue[idx] = eb;
            lut_written[idx] = 1'b1;
        end
    endtask

    function automatic logic signed [16:0] rand_entry();
        if ($urandom_range(0, 9) == 0) return 17'($urandom);
        return 17'($signed($urandom_range(0, 40960)) - 4096);
    endfunction

    task automatic send_load(logic [15:0] idx, logic signed [16:0] er,
                             logic signed [16:0] eg, logic signed [16:0] eb);
        send_item(REQ_LOAD, idx, er, eg, eb, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // loads any unwritten corner first so no unwritten entry is ever read
    task automatic send_pixel(logic [15:0] pr, logic [15:0] pg, logic [15:0] pb);
        int idx;
        for (int k = 0; k < 8; k++) begin
            idx = corner_index(pr, pg, pb, k);
            if (!lut_written[idx]) send_load(16'(idx), rand_entry(), rand_entry(), rand_entry());
        end
        send_item(REQ_PIXEL, 16'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                  pr, pg, pb);
    endtask

    function automatic logic [15:0] rand_pix();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE_VAL;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (mapped_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_grid(logic [5:0] n);
        wait_idle();
        i_grid_size_we <= 1'b1;
        i_grid_size <= n;
        @(negedge i_clk);
        i_grid_size_we <= 1'b0;
        i_grid_size <= 6'($urandom);
        grid_reg = n;
    endtask

    task automatic test_directed();
        send_load(16'd0, -17'sd65536, 17'sd65535, 17'sd0);
        send_load(16'd35937, 17'sd100, 17'sd100, 17'sd100);
        send_load(16'hFFFF, 17'sd100, 17'sd100, 17'sd100);
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(ONE_VAL, ONE_VAL, ONE_VAL);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd32769, 16'd0, 16'd32768);
        send_pixel(16'd16384, 16'd16384, 16'd16384);
        send_pixel(16'd1, 16'd32767, 16'd1024);
        send_load(16'd35936, 17'sd65535, -17'sd65536, 17'sd32768);
        send_pixel(ONE_VAL, ONE_VAL, ONE_VAL);
        set_grid(6'd2);
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd16384, ONE_VAL, 16'd8191);
        set_grid(6'd0);
        send_pixel(16'd12345, 16'd23456, 16'hFFFF);
        set_grid(6'd1);
        send_pixel(ONE_VAL, 16'd0, 16'd20000);
        set_grid(6'd63);
        send_pixel(16'd30000, 16'd5, ONE_VAL);
        set_grid(6'd34);
        send_pixel(16'd32767, 16'd32767, 16'd32767);
    endtask

    task automatic test_grid_sizes();
        logic [5:0] sizes[8] = '{6'd3, 6'd5, 6'd4, 6'd17, 6'd33, 6'd2, 6'd9, 6'd40};
        foreach (sizes[s]) begin
            set_grid(sizes[s]);
            repeat (5) send_pixel(rand_pix(), rand_pix(), rand_pix());
        end
    endtask

    task automatic test_backpressure();
        set_grid(6'd4);
        no_gaps = 1'b1;
        hold_cycles = 300;
        repeat (40) send_pixel(rand_pix(), rand_pix(), rand_pix());
        no_gaps = 1'b0;
    endtask

    task automatic test_random();
        for (int i = 0; item_count < ITEM_TARGET; i++) begin
            if (i % 25 == 24) set_grid(6'($urandom_range(0, 63)));
            no_gaps = (i % 40) < 10;
            case ($urandom_range(0, 9))
                0: send_load(16'($urandom), rand_entry(), rand_entry(), rand_entry());
                1: send_load(16'($urandom_range(0, STORE_DEPTH - 1)),
                             rand_entry(), rand_entry(), rand_entry());
                default: send_pixel(rand_pix(), rand_pix(), rand_pix());
            endcase
        end
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        int mode_left;
        int mode;
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            if (mode_left <= 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left = mode_left - 1;
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_mapped_pix want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mapped_q.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                         o_out_red, o_out_green, o_out_blue);
                error_count++;
            end else begin
                want = mapped_q.pop_front();
                if (o_out_red !== want.red) begin
                    $display("%0t: red expected %0d actual %0d", $time, want.red, o_out_red);
                    error_count++;
                end
                if (o_out_green !== want.green) begin
                    $display("%0t: green expected %0d actual %0d", $time, want.green,
                             o_out_green);
                    error_count++;
                end
                if (o_out_blue !== want.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue,
                             o_out_blue);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_grid_sizes();
        test_backpressure();
        test_random();
        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
